FILE: src/cmm_pkg.sv
`default_nettype none

package cmm_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 14;

    localparam int DATA_W    = 16;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    // item commands
    localparam logic CMD_LOAD_A = 1'b0;
    localparam logic CMD_LOAD_B = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] rows_a;
        logic [CFG_W-1:0] inner_dim;
        logic [CFG_W-1:0] cols_b;
    } cmm_cfg_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } cmm_state_t;

endpackage

`default_nettype wire

FILE: src/cmm_if.sv
`default_nettype none

interface cmm_item_if import cmm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic signed [DATA_W-1:0] elem_real;
    logic signed [DATA_W-1:0] elem_imag;
    logic                     is_last;

    modport source (output valid, command, elem_real, elem_imag, is_last, input ready);
    modport sink   (input valid, command, elem_real, elem_imag, is_last, output ready);
endinterface

interface cmm_result_if import cmm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] prod_real;
    logic signed [DATA_W-1:0] prod_imag;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     last_of_run;
    logic                     saturated;

    modport source (output valid, prod_real, prod_imag, out_row, out_col, last_of_run,
                    saturated, input ready);
    modport sink   (input valid, prod_real, prod_imag, out_row, out_col, last_of_run,
                    saturated, output ready);
endinterface

interface cmm_cfg_if import cmm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/complex_matrix_multiply.sv
// Complex matrix multiplier, signed Q1.14 (FRAC_BITS fraction bits).
// item channel: each transaction loads the next element of A (command 0) or B
//   (command 1) in row-major order; is_last closes the matrix being loaded.
// cfg channel: always ready; index 0 rows_a, 1 inner_dim, 2 cols_b (4 bits each).
//   Write only while no run is in progress.
// result channel: after the last element of B, rows_a * cols_b transactions in
//   row-major order, with row, column, last_of_run and saturated marks; a
//   dimension of 0 acts as 1 and one above MAX_DIM acts as MAX_DIM.
// Each product element is formed in order: one store read per inner term
//   through the single read port of each store, the registered multiply, the
//   accumulate, a wait until the pipeline is empty, then rounding into the
//   result register.
// item is not ready from the closing B transaction until the final result is
//   registered. A stalled result holds the output register and the next element
//   waits, finished, until the register frees.
// Reset clears the fill counts and sets all three dimensions to 8; store contents
//   are undefined until loaded.
`default_nettype none

module complex_matrix_multiply import cmm_pkg::*; #(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    cmm_cfg_if.sink      cfg,
    cmm_item_if.sink     item,
    cmm_result_if.source result
);

    cmm_cfg_t dims_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg.rows_a    <= CFG_RESET;
            dims_reg.inner_dim <= CFG_RESET;
            dims_reg.cols_b    <= CFG_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ROWS_A:    dims_reg.rows_a    <= cfg.data;
                REG_INNER_DIM: dims_reg.inner_dim <= cfg.data;
                REG_COLS_B:    dims_reg.cols_b    <= cfg.data;
                default:       dims_reg           <= dims_reg;
            endcase
        end
    end

    cmm_engine #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .dims   (dims_reg),
        .item   (item),
        .result (result)
    );

endmodule

`default_nettype wire

FILE: src/cmm_engine.sv
`default_nettype none

module cmm_engine import cmm_pkg::*; #(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cmm_cfg_t dims,
    cmm_item_if.sink      item,
    cmm_result_if.source  result
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int FCW    = $clog2(DEPTH + 1);
    localparam int DW     = $clog2(MAX_DIM);
    localparam int EW     = $clog2(MAX_DIM + 1);
    localparam int PROD_W = 2 * DATA_W;
    localparam int TERM_W = PROD_W + 1;
    localparam int ACC_W  = TERM_W + $clog2(MAX_DIM);
    localparam int RW     = ACC_W + 1;

    localparam logic signed [RW-1:0] RND_HALF = RW'(1) << (FRAC_BITS - 1);
    localparam logic signed [RW-1:0] SAT_MAX  = RW'(32'sd32767);
    localparam logic signed [RW-1:0] SAT_MIN  = RW'(-32'sd32768);

    function automatic logic [EW-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [EW-1:0] d;
        if (v == '0)
            d = EW'(1);
        else if (int'(v) > MAX_DIM)
            d = EW'(MAX_DIM);
        else
            d = EW'(v);
        return d;
    endfunction

    // returns {clip, value}
    function automatic logic [DATA_W:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [RW-1:0] sum;
        logic signed [RW-1:0] shifted;
        logic [DATA_W:0]      res;
        sum     = $signed({acc[ACC_W-1], acc}) + RND_HALF;
        shifted = sum >>> FRAC_BITS;
        if (shifted > SAT_MAX)
            res = {1'b1, SAT_MAX[DATA_W-1:0]};
        else if (shifted < SAT_MIN)
            res = {1'b1, SAT_MIN[DATA_W-1:0]};
        else
            res = {1'b0, shifted[DATA_W-1:0]};
        return res;
    endfunction

    logic [EW-1:0] nr;
    logic [EW-1:0] nk;
    logic [EW-1:0] nc;

    assign nr = eff_dim(dims.rows_a);
    assign nk = eff_dim(dims.inner_dim);
    assign nc = eff_dim(dims.cols_b);

    cmm_state_t state_reg, state_next;
    logic [FCW-1:0] a_fill_reg, a_fill_next;
    logic [FCW-1:0] b_fill_reg, b_fill_next;
    logic [DW-1:0]  i_reg, i_next;
    logic [DW-1:0]  r_reg, r_next;
    logic [DW-1:0]  c_reg, c_next;
    logic [AW-1:0]  a_addr_reg, a_addr_next;
    logic [AW-1:0]  a_base_reg, a_base_next;
    logic [AW-1:0]  b_addr_reg, b_addr_next;
    logic           v1_reg;
    logic           v2_reg;
    logic           out_valid_reg;

    logic [PROD_W-1:0] a_mem [DEPTH];
    logic [PROD_W-1:0] b_mem [DEPTH];
    logic [PROD_W-1:0] rd_a_reg;
    logic [PROD_W-1:0] rd_b_reg;

    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic signed [TERM_W-1:0] term_re, term_im;

    logic                     item_fire;
    logic                     wr_a, wr_b;
    logic                     issue;
    logic                     emit;
    logic                     acc_clear;
    logic                     last_term;
    logic                     last_col;
    logic                     last_row;
    logic                     out_free;
    logic [DATA_W:0]          rs_re, rs_im;

    logic signed [DATA_W-1:0] out_real_reg, out_imag_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic                     out_last_reg, out_sat_reg;

    assign item.ready = (state_reg == ST_LOAD);
    assign item_fire  = item.valid && item.ready;
    assign wr_a = item_fire && (item.command == CMD_LOAD_A) && (int'(a_fill_reg) < DEPTH);
    assign wr_b = item_fire && (item.command == CMD_LOAD_B) && (int'(b_fill_reg) < DEPTH);

    assign last_term = (EW'(i_reg) + EW'(1)) == nk;
    assign last_col  = (EW'(c_reg) + EW'(1)) == nc;
    assign last_row  = (EW'(r_reg) + EW'(1)) == nr;
    assign out_free  = !out_valid_reg || result.ready;

    // Stores: one write port from the load side, one read port for the compute loop.
    // Loads stop while computing, so a read never meets a pending write.
    always_ff @(posedge clk)
    begin
        if (wr_a)
            a_mem[a_fill_reg[AW-1:0]] <= {item.elem_real, item.elem_imag};
        rd_a_reg <= a_mem[a_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
            b_mem[b_fill_reg[AW-1:0]] <= {item.elem_real, item.elem_imag};
        rd_b_reg <= b_mem[b_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            a_fill_reg <= '0;
            b_fill_reg <= '0;
            i_reg      <= '0;
            r_reg      <= '0;
            c_reg      <= '0;
            a_addr_reg <= '0;
            a_base_reg <= '0;
            b_addr_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            a_fill_reg <= a_fill_next;
            b_fill_reg <= b_fill_next;
            i_reg      <= i_next;
            r_reg      <= r_next;
            c_reg      <= c_next;
            a_addr_reg <= a_addr_next;
            a_base_reg <= a_base_next;
            b_addr_reg <= b_addr_next;
            v1_reg     <= issue;
            v2_reg     <= v1_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        a_fill_next = a_fill_reg;
        b_fill_next = b_fill_reg;
        i_next      = i_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        a_addr_next = a_addr_reg;
        a_base_next = a_base_reg;
        b_addr_next = b_addr_reg;
        issue       = 1'b0;
        emit        = 1'b0;
        acc_clear   = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (wr_a)
                    a_fill_next = a_fill_reg + FCW'(1);
                if (wr_b)
                    b_fill_next = b_fill_reg + FCW'(1);
                if (item_fire && item.is_last)
                begin
                    if (item.command == CMD_LOAD_A)
                        a_fill_next = '0;
                    else
                    begin
                        state_next  = ST_ISSUE;
                        i_next      = '0;
                        r_next      = '0;
                        c_next      = '0;
                        a_addr_next = '0;
                        a_base_next = '0;
                        b_addr_next = '0;
                        acc_clear   = 1'b1;
                    end
                end
            end
            ST_ISSUE:
            begin
                issue = 1'b1;
                if (last_term)
                    state_next = ST_DRAIN;
                else
                begin
                    i_next      = i_reg + DW'(1);
                    a_addr_next = a_addr_reg + AW'(1);
                    b_addr_next = b_addr_reg + AW'(nc);
                end
            end
            ST_DRAIN:
            begin
                // wait for the last term to reach the accumulator
                if (!v1_reg && !v2_reg)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    acc_clear = 1'b1;
                    i_next    = '0;
                    if (last_col)
                    begin
                        c_next      = '0;
                        b_addr_next = '0;
                        if (last_row)
                        begin
                            state_next  = ST_LOAD;
                            a_fill_next = '0;
                            b_fill_next = '0;
                        end
                        else
                        begin
                            state_next  = ST_ISSUE;
                            r_next      = r_reg + DW'(1);
                            a_base_next = a_base_reg + AW'(nk);
                            a_addr_next = a_base_reg + AW'(nk);
                        end
                    end
                    else
                    begin
                        state_next  = ST_ISSUE;
                        c_next      = c_reg + DW'(1);
                        a_addr_next = a_base_reg;
                        b_addr_next = AW'(c_reg) + AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Complex multiply: four partial products, registered.
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            p_rr_reg <= $signed(rd_a_reg[PROD_W-1:DATA_W]) * $signed(rd_b_reg[PROD_W-1:DATA_W]);
            p_ii_reg <= $signed(rd_a_reg[DATA_W-1:0]) * $signed(rd_b_reg[DATA_W-1:0]);
            p_ri_reg <= $signed(rd_a_reg[PROD_W-1:DATA_W]) * $signed(rd_b_reg[DATA_W-1:0]);
            p_ir_reg <= $signed(rd_a_reg[DATA_W-1:0]) * $signed(rd_b_reg[PROD_W-1:DATA_W]);
        end
    end

    assign term_re = TERM_W'(p_rr_reg) - TERM_W'(p_ii_reg);
    assign term_im = TERM_W'(p_ri_reg) + TERM_W'(p_ir_reg);

    always_ff @(posedge clk)
    begin
        if (acc_clear)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(term_re);
            acc_im_reg <= acc_im_reg + ACC_W'(term_im);
        end
    end

    assign rs_re = round_sat(acc_re_reg);
    assign rs_im = round_sat(acc_im_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_real_reg <= $signed(rs_re[DATA_W-1:0]);
            out_imag_reg <= $signed(rs_im[DATA_W-1:0]);
            out_row_reg  <= IDX_W'(r_reg);
            out_col_reg  <= IDX_W'(c_reg);
            out_last_reg <= last_col && last_row;
            out_sat_reg  <= rs_re[DATA_W] || rs_im[DATA_W];
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.prod_real   = out_real_reg;
    assign result.prod_imag   = out_imag_reg;
    assign result.out_row     = out_row_reg;
    assign result.out_col     = out_col_reg;
    assign result.last_of_run = out_last_reg;
    assign result.saturated   = out_sat_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(a_fill_reg) <= DEPTH && int'(b_fill_reg) <= DEPTH)
        else $error("fill count beyond store depth");

    emit_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> !v1_reg && !v2_reg)
        else $error("result taken before accumulation finished");

    issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ISSUE |-> EW'(i_reg) < nk && EW'(r_reg) < nr && EW'(c_reg) < nc)
        else $error("compute index out of range");

    final_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit && last_col && last_row |=> state_reg == ST_LOAD && a_fill_reg == '0)
        else $error("run did not end after final element");

    load_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |-> !v1_reg && !issue)
        else $error("memory reads in flight while loading");

endmodule

`default_nettype wire

FILE: dv/complex_matrix_multiply_tb.sv
`timescale 1ns / 1ps

module complex_matrix_multiply_tb;

    import cmm_pkg::*;

    localparam int          STORE_DEPTH   = MAX_DIM_DEF * MAX_DIM_DEF;
    localparam int          SETTLE_CYCLES = 2 * (MAX_DIM_DEF + 4);
    localparam int          RANDOM_ITEMS  = 430;
    localparam int unsigned STALL_LIMIT   = 2000;

    typedef struct packed {
        logic                     cmd;
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     last;
    } elem_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic                     last;
        logic                     sat;
    } prod_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        elem_t                elem;
        bit                   pinned;
        prod_t                want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    cmm_cfg_if    cfg_bus ();
    cmm_item_if   item_bus ();
    cmm_result_if result_bus ();

    complex_matrix_multiply dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .item   (item_bus),
        .result (result_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // product model state
    cmm_cfg_t                 dims = '{rows_a: CFG_RESET, inner_dim: CFG_RESET, cols_b: CFG_RESET};
    logic signed [DATA_W-1:0] a_re [STORE_DEPTH];
    logic signed [DATA_W-1:0] a_im [STORE_DEPTH];
    logic signed [DATA_W-1:0] b_re [STORE_DEPTH];
    logic signed [DATA_W-1:0] b_im [STORE_DEPTH];
    int unsigned              a_next = 0;
    int unsigned              b_next = 0;
    // one past the highest position written since reset; loads always start at position 0
    int unsigned              a_filled_to = 0;
    int unsigned              b_filled_to = 0;

    prod_t       pending_products [$];
    prod_t       want_now;
    plan_row_t   plan [$];
    bit          gaps_on = 1'b1;
    int unsigned sent_items = 0;
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;

    function automatic int unsigned dim_of(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM_DEF)
            return MAX_DIM_DEF;
        return 32'(v);
    endfunction

    function automatic logic signed [DATA_W-1:0] round_clip(input longint acc, inout logic clip);
        longint v;
        v = (acc + (longint'(1) <<< (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
        if (v > 32767)
        begin
            v    = 32767;
            clip = 1'b1;
        end
        else if (v < -32768)
        begin
            v    = -32768;
            clip = 1'b1;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic void form_product();
        int unsigned nr, nk, nc;
        longint      acc_re, acc_im, ar, ai, br, bi;
        logic        clip;
        prod_t       p;
        nr = dim_of(dims.rows_a);
        nk = dim_of(dims.inner_dim);
        nc = dim_of(dims.cols_b);
        for (int unsigned r = 0; r < nr; r++)
        begin
            for (int unsigned c = 0; c < nc; c++)
            begin
                acc_re = 0;
                acc_im = 0;
                clip   = 1'b0;
                for (int unsigned k = 0; k < nk; k++)
                begin
                    ar = longint'(a_re[r * nk + k]);
                    ai = longint'(a_im[r * nk + k]);
                    br = longint'(b_re[k * nc + c]);
                    bi = longint'(b_im[k * nc + c]);
                    acc_re += ar * br - ai * bi;
                    acc_im += ar * bi + ai * br;
                end
                p.re   = round_clip(acc_re, clip);
                p.im   = round_clip(acc_im, clip);
                p.row  = r[IDX_W-1:0];
                p.col  = c[IDX_W-1:0];
                p.last = (r == nr - 1) && (c == nc - 1);
                p.sat  = clip;
                pending_products.push_back(p);
            end
        end
    endfunction

    function automatic void take_element(input elem_t e);
        if (e.cmd == CMD_LOAD_A)
        begin
            // drop writes past the end of the store
            if (a_next < STORE_DEPTH)
            begin
                a_re[a_next] = e.re;
                a_im[a_next] = e.im;
                a_next++;
            end
            if (a_next > a_filled_to)
                a_filled_to = a_next;
            if (e.last)
                a_next = 0;
        end
        else
        begin
            if (b_next < STORE_DEPTH)
            begin
                b_re[b_next] = e.re;
                b_im[b_next] = e.im;
                b_next++;
            end
            if (b_next > b_filled_to)
                b_filled_to = b_next;
            if (e.last)
            begin
                form_product();
                a_next = 0;
                b_next = 0;
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic signed [DATA_W-1:0] want_v,
                                        input logic signed [DATA_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_products.size() == 0)
            begin
                $error("product element with nothing expected: row %0d col %0d",
                       result_bus.out_row, result_bus.out_col);
                fail_count++;
            end
            else
            begin
                want_now = pending_products.pop_front();
                check_field("prod_real", want_now.re, result_bus.prod_real);
                check_field("prod_imag", want_now.im, result_bus.prod_imag);
                check_field("out_row", DATA_W'(want_now.row), DATA_W'(result_bus.out_row));
                check_field("out_col", DATA_W'(want_now.col), DATA_W'(result_bus.out_col));
                check_field("last_of_run", DATA_W'(want_now.last),
                            DATA_W'(result_bus.last_of_run));
                check_field("saturated", DATA_W'(want_now.sat), DATA_W'(result_bus.saturated));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("complex_matrix_multiply_tb NOT OK");
            $finish;
        end
    end

    always @(negedge clk)
        result_bus.ready <= !gaps_on || ($urandom_range(99) >= 34);

    task automatic send_element(input elem_t e);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 34)
        begin
            item_bus.valid = 1'b0;
            @(negedge clk);
        end
        item_bus.valid     = 1'b1;
        item_bus.command   = e.cmd;
        item_bus.elem_real = e.re;
        item_bus.elem_imag = e.im;
        item_bus.is_last   = e.last;
        do
            @(posedge clk);
        while (item_bus.ready !== 1'b1);
        take_element(e);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        case (idx)
            REG_ROWS_A:    dims.rows_a    = val;
            REG_INNER_DIM: dims.inner_dim = val;
            REG_COLS_B:    dims.cols_b    = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // hold the item channel until every product element is back, then let the block settle
    task automatic drain_products();
        @(negedge clk);
        item_bus.valid = 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3, 4: return DATA_W'($urandom_range(8191) - 4096);
            default: return DATA_W'($urandom());
        endcase
    endfunction

    function automatic elem_t rand_elem(input logic cmd, input logic last);
        elem_t e;
        e.cmd  = cmd;
        e.re   = pick_value();
        e.im   = pick_value();
        e.last = last;
        return e;
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(12))
            0:       return 4'd0;
            1:       return 4'd15;
            2:       return 4'd8;
            3:       return CFG_W'($urandom_range(9, 14));
            default: return CFG_W'($urandom_range(1, 4));
        endcase
    endfunction

    // a short load is only allowed where earlier runs already filled the positions it reads
    function automatic int unsigned pick_len(input int unsigned need, input int unsigned have,
                                             input bit overlong);
        int unsigned roll;
        roll = $urandom_range(29);
        if (overlong || roll == 0)
            return STORE_DEPTH + $urandom_range(1, 3);
        if (roll < 6 && have >= need)
            return $urandom_range(0, need - 1);
        return need;
    endfunction

    task automatic run_random_multiply(input bit long_a, input bit long_b);
        elem_t       a_part [$];
        elem_t       b_part [$];
        elem_t       seq [$];
        elem_t       b_close;
        int unsigned na, nb, len, a_have;
        bit          a_close;
        na     = dim_of(dims.rows_a) * dim_of(dims.inner_dim);
        nb     = dim_of(dims.inner_dim) * dim_of(dims.cols_b);
        a_have = a_filled_to;
        // sometimes load a throwaway prefix of A first
        if ($urandom_range(4) == 0)
        begin
            len = $urandom_range(1, na);
            for (int unsigned k = 0; k < len; k++)
                a_part.push_back(rand_elem(CMD_LOAD_A, k == len - 1));
            if (len > a_have)
                a_have = len;
        end
        len     = pick_len(na, a_have, long_a);
        a_close = ($urandom_range(5) != 0);
        for (int unsigned k = 0; k < len; k++)
            a_part.push_back(rand_elem(CMD_LOAD_A, a_close && (k == len - 1)));
        len = pick_len(nb, b_filled_to, long_b);
        if (len == 0)
            len = 1;
        for (int unsigned k = 0; k < len; k++)
            b_part.push_back(rand_elem(CMD_LOAD_B, k == len - 1));
        if ($urandom_range(3) == 0)
        begin
            // interleave A and B loads; the closing B transaction stays last
            b_close = b_part.pop_back();
            while (a_part.size() != 0 || b_part.size() != 0)
            begin
                if (b_part.size() == 0 || (a_part.size() != 0 && $urandom_range(1) == 0))
                    seq.push_back(a_part.pop_front());
                else
                    seq.push_back(b_part.pop_front());
            end
            seq.push_back(b_close);
        end
        else
        begin
            foreach (a_part[k])
                seq.push_back(a_part[k]);
            foreach (b_part[k])
                seq.push_back(b_part[k]);
        end
        foreach (seq[k])
        begin
            send_element(seq[k]);
            sent_items++;
        end
    endtask

    function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        plan_row_t row;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        row.elem    = '0;
        row.pinned  = 1'b0;
        row.want    = '0;
        plan.push_back(row);
    endfunction

    function automatic void plan_elem(input logic cmd, input logic signed [DATA_W-1:0] re,
                                      input logic signed [DATA_W-1:0] im, input logic last);
        plan_row_t row;
        row.is_cfg  = 1'b0;
        row.reg_idx = REG_ROWS_A;
        row.reg_val = '0;
        row.elem    = '{cmd, re, im, last};
        row.pinned  = 1'b0;
        row.want    = '0;
        plan.push_back(row);
    endfunction

    function automatic void plan_check(input logic cmd, input logic signed [DATA_W-1:0] re,
                                       input logic signed [DATA_W-1:0] im, input logic last,
                                       input prod_t want);
        plan_elem(cmd, re, im, last);
        plan[$].pinned = 1'b1;
        plan[$].want   = want;
    endfunction

    initial
    begin
        bit in_cfg;
        int run_idx;

        rst_n              = 1'b0;
        item_bus.valid     = 1'b0;
        item_bus.command   = CMD_LOAD_A;
        item_bus.elem_real = '0;
        item_bus.elem_imag = '0;
        item_bus.is_last   = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = REG_ROWS_A;
        cfg_bus.data       = '0;
        result_bus.ready   = 1'b0;

        // 1x1 products with results read straight off the operands
        plan_cfg(REG_ROWS_A, 4'd1);
        plan_cfg(REG_INNER_DIM, 4'd1);
        plan_cfg(REG_COLS_B, 4'd1);
        plan_elem(CMD_LOAD_A, 16'sd16384, 16'sd0, 1'b1);
        plan_check(CMD_LOAD_B, 16'sd16384, 16'sd0, 1'b1, '{16'sd16384, 16'sd0, 3'd0, 3'd0, 1'b1, 1'b0});
        plan_elem(CMD_LOAD_A, 16'sh8000, 16'sh8000, 1'b1);
        plan_check(CMD_LOAD_B, 16'sh8000, 16'sh8000, 1'b1, '{16'sd0, 16'sh7FFF, 3'd0, 3'd0, 1'b1, 1'b1});
        plan_elem(CMD_LOAD_A, 16'sh7FFF, 16'sh7FFF, 1'b1);
        plan_check(CMD_LOAD_B, 16'sh7FFF, 16'sh8000, 1'b1, '{16'sh7FFF, -16'sd2, 3'd0, 3'd0, 1'b1, 1'b1});
        plan_elem(CMD_LOAD_A, 16'sh8000, 16'sd0, 1'b1);
        plan_check(CMD_LOAD_B, 16'sh7FFF, 16'sd0, 1'b1, '{16'sh8000, 16'sd0, 3'd0, 3'd0, 1'b1, 1'b1});
        // half-way ties round up
        plan_elem(CMD_LOAD_A, 16'sd1, 16'sd0, 1'b1);
        plan_check(CMD_LOAD_B, 16'sd8192, 16'sd0, 1'b1, '{16'sd1, 16'sd0, 3'd0, 3'd0, 1'b1, 1'b0});
        plan_elem(CMD_LOAD_A, -16'sd1, 16'sd0, 1'b1);
        plan_check(CMD_LOAD_B, 16'sd8192, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 3'd0, 3'd0, 1'b1, 1'b0});
        // zero dimension acts as one
        plan_cfg(REG_ROWS_A, 4'd0);
        plan_cfg(REG_INNER_DIM, 4'd2);
        plan_elem(CMD_LOAD_A, 16'sd12000, -16'sd5000, 1'b0);
        plan_elem(CMD_LOAD_A, -16'sd20000, 16'sd3000, 1'b1);
        plan_elem(CMD_LOAD_B, 16'sd7000, 16'sd9000, 1'b0);
        plan_elem(CMD_LOAD_B, 16'sh8000, 16'sh7FFF, 1'b1);
        // oversized dimension acts as the maximum
        plan_cfg(REG_ROWS_A, 4'd1);
        plan_cfg(REG_INNER_DIM, 4'd1);
        plan_cfg(REG_COLS_B, 4'd15);
        plan_elem(CMD_LOAD_A, 16'sh7FFF, 16'sh8000, 1'b1);
        plan_elem(CMD_LOAD_B, 16'sd16384, 16'sd0, 1'b0);
        plan_elem(CMD_LOAD_B, 16'sd0, 16'sd16384, 1'b0);
        plan_elem(CMD_LOAD_B, 16'sh8000, 16'sh8000, 1'b0);
        plan_elem(CMD_LOAD_B, 16'sh7FFF, 16'sh7FFF, 1'b0);
        plan_elem(CMD_LOAD_B, -16'sd1, 16'sd1, 1'b0);
        plan_elem(CMD_LOAD_B, 16'sd4096, -16'sd4096, 1'b0);
        plan_elem(CMD_LOAD_B, 16'sh5555, 16'shAAAA, 1'b0);
        plan_elem(CMD_LOAD_B, 16'shAAAA, 16'sh5555, 1'b1);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        in_cfg = 1'b0;
        foreach (plan[n])
        begin
            if (plan[n].is_cfg)
            begin
                if (!in_cfg)
                    drain_products();
                write_reg(plan[n].reg_idx, plan[n].reg_val);
            end
            else
            begin
                send_element(plan[n].elem);
                sent_items++;
                if (plan[n].pinned)
                    pending_products[$] = plan[n].want;
            end
            in_cfg = plan[n].is_cfg;
        end

        run_idx = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            // one long stretch with both sides streaming
            gaps_on = !(sent_items >= 150 && sent_items < 260);
            if (run_idx == 0 || $urandom_range(2) == 0)
            begin
                drain_products();
                write_reg(REG_ROWS_A, pick_dim());
                write_reg(REG_INNER_DIM, pick_dim());
                write_reg(REG_COLS_B, pick_dim());
            end
            run_random_multiply(run_idx == 0, run_idx == 1);
            run_idx++;
        end
        gaps_on = 1'b1;

        drain_products();
        if (fail_count == 0)
            $display("complex_matrix_multiply_tb OK");
        else
            $display("complex_matrix_multiply_tb NOT OK");
        $finish;
    end

endmodule

FILE: files.f
src/cmm_pkg.sv
src/cmm_if.sv
src/cmm_engine.sv
src/complex_matrix_multiply.sv
dv/complex_matrix_multiply_tb.sv
